### rtl/date_time_normalizer_macros.svh
// ----------------------------------------------------------------------------
// Date/time normalizer assertion macros
// Concurrent assertion shorthands clocked on clk_i, gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef DATE_TIME_NORMALIZER_MACROS_SVH
`define DATE_TIME_NORMALIZER_MACROS_SVH

// same-cycle implication
`define DTN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dtn_pkg.sv
// ----------------------------------------------------------------------------
// Date/time normalizer package
// Field widths, sequencer phases, control structs and the month length table.
// ----------------------------------------------------------------------------
package dtn_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthInW = 8;
  localparam int unsigned DayInW  = 16;
  localparam int unsigned HourInW = 16;
  localparam int unsigned MinInW  = 16;

  localparam int unsigned MonthOutW = 4;
  localparam int unsigned DayOutW   = 5;
  localparam int unsigned HourOutW  = 5;
  localparam int unsigned MinOutW   = 6;

  localparam int unsigned AluW  = 17;
  localparam int unsigned YrW   = 15;
  localparam int unsigned QuoW  = 12;
  localparam int unsigned StepW = 4;

  localparam logic [AluW-1:0] MinPerHour  = AluW'(60);
  localparam logic [AluW-1:0] HourPerDay  = AluW'(24);
  localparam logic [AluW-1:0] MonPerYear  = AluW'(12);
  localparam logic [AluW-1:0] LeapCycle   = AluW'(400);
  localparam logic [YrW-1:0]  YearMax     = YrW'(16383);

  localparam logic [StepW-1:0] MinStepTop  = StepW'(10);
  localparam logic [StepW-1:0] HourStepTop = StepW'(11);
  localparam logic [StepW-1:0] MonStepTop  = StepW'(4);
  localparam logic [StepW-1:0] YrStepTop   = StepW'(5);

  localparam logic [3:0] MonthFeb  = 4'd1;
  localparam logic [3:0] MonthLast = 4'd11;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_MIN_DIV,
    PH_MIN_ADD,
    PH_HR_DIV,
    PH_HR_ADD,
    PH_MON_DIV,
    PH_MON_ADD,
    PH_YR_DIV,
    PH_WALK,
    PH_DONE
  } phase_e;

  typedef struct packed {
    phase_e           phase;
    logic [StepW-1:0] step;
    logic             load;
    logic             emit;
  } ctrl_t;

  typedef struct packed {
    logic walk_done;
  } stat_t;

  function automatic logic [DayOutW-1:0] month_days(input logic [3:0] idx, input logic leap);
    logic [DayOutW-1:0] d;
    case (idx)
      MonthFeb:                  d = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

### rtl/dtn_if.sv
// ----------------------------------------------------------------------------
// Date/time normalizer channels
// Valid/ready channels for the raw timestamp and the normalized result.
// ----------------------------------------------------------------------------
interface dtn_in_if;
  import dtn_pkg::*;
  logic               valid;
  logic               ready;
  logic [YearW-1:0]   year_in;
  logic [MonthInW-1:0] month_in;
  logic [DayInW-1:0]  day_in;
  logic [HourInW-1:0] hour_in;
  logic [MinInW-1:0]  minute_in;

  modport source (output valid, year_in, month_in, day_in, hour_in, minute_in,
                  input ready);
  modport sink   (input valid, year_in, month_in, day_in, hour_in, minute_in,
                  output ready);
endinterface

interface dtn_out_if;
  import dtn_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [YearW-1:0]     year_out;
  logic [MonthOutW-1:0] month_out;
  logic [DayOutW-1:0]   day_out;
  logic [HourOutW-1:0]  hour_out;
  logic [MinOutW-1:0]   minute_out;

  modport source (output valid, year_out, month_out, day_out, hour_out, minute_out,
                  input ready);
  modport sink   (input valid, year_out, month_out, day_out, hour_out, minute_out,
                  output ready);
endinterface

### rtl/dtn_alu.sv
// ----------------------------------------------------------------------------
// Date/time normalizer shared adder
// One add/subtract unit with carry out, used by every divide, carry and walk phase.
// ----------------------------------------------------------------------------
module dtn_alu (
  input  logic [dtn_pkg::AluW-1:0] a_i,
  input  logic [dtn_pkg::AluW-1:0] b_i,
  input  logic                     sub_i,
  output logic [dtn_pkg::AluW-1:0] res_o,
  output logic                     carry_o
);
  import dtn_pkg::*;

  logic [AluW-1:0] b_eff;

  assign b_eff = sub_i ? ~b_i : b_i;
  assign {carry_o, res_o} = {1'b0, a_i} + {1'b0, b_eff} + {{AluW{1'b0}}, sub_i};

endmodule

### rtl/dtn_ctrl.sv
// ----------------------------------------------------------------------------
// Date/time normalizer sequencer
// Steps the shared adder through the divide, carry and month walk phases.
// ----------------------------------------------------------------------------
module dtn_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_free_i,
  input  dtn_pkg::stat_t stat_i,
  output dtn_pkg::ctrl_t ctrl_o
);
  import dtn_pkg::*;

  phase_e           phase_q, phase_d;
  logic [StepW-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= '0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (in_valid_i) begin
          phase_d = PH_MIN_DIV;
          step_d  = MinStepTop;
        end
      end
      PH_MIN_DIV: begin
        if (step_q == '0) phase_d = PH_MIN_ADD;
        else step_d = step_q - StepW'(1);
      end
      PH_MIN_ADD: begin
        phase_d = PH_HR_DIV;
        step_d  = HourStepTop;
      end
      PH_HR_DIV: begin
        if (step_q == '0) phase_d = PH_HR_ADD;
        else step_d = step_q - StepW'(1);
      end
      PH_HR_ADD: begin
        phase_d = PH_MON_DIV;
        step_d  = MonStepTop;
      end
      PH_MON_DIV: begin
        if (step_q == '0) phase_d = PH_MON_ADD;
        else step_d = step_q - StepW'(1);
      end
      PH_MON_ADD: begin
        phase_d = PH_YR_DIV;
        step_d  = YrStepTop;
      end
      PH_YR_DIV: begin
        if (step_q == '0) phase_d = PH_WALK;
        else step_d = step_q - StepW'(1);
      end
      PH_WALK: begin
        if (stat_i.walk_done) phase_d = PH_DONE;
      end
      PH_DONE: begin
        if (out_free_i) phase_d = PH_IDLE;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.phase = phase_q;
    ctrl_o.step  = step_q;
    ctrl_o.load  = (phase_q == PH_IDLE) && in_valid_i;
    ctrl_o.emit  = (phase_q == PH_DONE) && out_free_i;
  end

endmodule

### rtl/date_time_normalizer.sv
// ----------------------------------------------------------------------------
// Date/time normalizer
// Carries overflowing minute, hour, day and month fields into a calendar date.
// ----------------------------------------------------------------------------
// Usage:
//   in_i takes one raw timestamp per valid/ready handshake; out_o returns one
//   normalized item for each input item, in order.
//   in_i.ready is high only while the sequencer is idle; one item is worked
//   on at a time on a single shared 17-bit adder.
//   Processing: shift-subtract division and carry adds (minutes, hours,
//   months, year mod 400), then a month walk that takes one month off the
//   day count per step until a step finds the day fits, then the output
//   register is loaded. The length of the walk grows with the day count.
//   A new item is taken only once the last result is loaded; in_i.ready
//   rises together with that load.
//   The result sits in an output register; if out_o is stalled, the
//   sequencer waits in its final phase and in_i stays not ready.
//   Reset clears the sequencer and the output valid; no item is in flight.
// ----------------------------------------------------------------------------
`include "date_time_normalizer_macros.svh"

module date_time_normalizer (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtn_in_if.sink    in_i,
  dtn_out_if.source out_o
);
  import dtn_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  logic [MinInW-1:0]   min_q;
  logic [AluW-1:0]     hr_q;
  logic [AluW-1:0]     day_q;
  logic [MonthInW-1:0] mon_q;
  logic [YrW-1:0]      yr_q;
  logic [YrW-1:0]      ymod_q;
  logic [QuoW-1:0]     quo_q;

  logic                 out_valid_q;
  logic [YearW-1:0]     year_out_q;
  logic [MonthOutW-1:0] month_out_q;
  logic [DayOutW-1:0]   day_out_q;
  logic [HourOutW-1:0]  hour_out_q;
  logic [MinOutW-1:0]   minute_out_q;

  logic [AluW-1:0] alu_a, alu_b, alu_res;
  logic            alu_sub, alu_carry;
  logic            leap;
  logic            out_free;
  logic [QuoW-1:0] quo_bit;

  assign out_free = !out_valid_q || out_o.ready;
  assign quo_bit  = QuoW'(1) << ctrl.step;

  assign leap = (ymod_q[1:0] == 2'b00) &&
                (ymod_q != YrW'(100)) && (ymod_q != YrW'(200)) && (ymod_q != YrW'(300));

  dtn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_free_i (out_free),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  dtn_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (ctrl.phase)
      PH_MIN_DIV: begin
        alu_a = AluW'(min_q);
        alu_b = MinPerHour << ctrl.step;
      end
      PH_MIN_ADD: begin
        alu_a   = hr_q;
        alu_b   = AluW'(quo_q);
        alu_sub = 1'b0;
      end
      PH_HR_DIV: begin
        alu_a = hr_q;
        alu_b = HourPerDay << ctrl.step;
      end
      PH_HR_ADD: begin
        alu_a   = day_q;
        alu_b   = AluW'(quo_q);
        alu_sub = 1'b0;
      end
      PH_MON_DIV: begin
        alu_a = AluW'(mon_q);
        alu_b = MonPerYear << ctrl.step;
      end
      PH_MON_ADD: begin
        alu_a   = AluW'(yr_q);
        alu_b   = AluW'(quo_q);
        alu_sub = 1'b0;
      end
      PH_YR_DIV: begin
        alu_a = AluW'(ymod_q);
        alu_b = LeapCycle << ctrl.step;
      end
      PH_WALK: begin
        alu_a = day_q;
        alu_b = AluW'(month_days(mon_q[3:0], leap));
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // day fits its month: subtraction borrowed or landed on zero
  assign stat.walk_done = !alu_carry || (alu_res == '0);

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      min_q  <= in_i.minute_in;
      hr_q   <= AluW'(in_i.hour_in);
      day_q  <= AluW'(in_i.day_in);
      mon_q  <= (in_i.month_in == '0) ? '0 : in_i.month_in - MonthInW'(1);
      yr_q   <= YrW'(in_i.year_in);
      quo_q  <= '0;
    end else begin
      case (ctrl.phase)
        PH_MIN_DIV: begin
          if (alu_carry) begin
            min_q <= alu_res[MinInW-1:0];
            quo_q <= quo_q | quo_bit;
          end
        end
        PH_MIN_ADD: begin
          hr_q  <= alu_res;
          quo_q <= '0;
        end
        PH_HR_DIV: begin
          if (alu_carry) begin
            hr_q  <= alu_res;
            quo_q <= quo_q | quo_bit;
          end
        end
        PH_HR_ADD: begin
          day_q <= alu_res;
          quo_q <= '0;
        end
        PH_MON_DIV: begin
          if (alu_carry) begin
            mon_q <= alu_res[MonthInW-1:0];
            quo_q <= quo_q | quo_bit;
          end
        end
        PH_MON_ADD: begin
          yr_q   <= alu_res[YrW-1:0];
          ymod_q <= alu_res[YrW-1:0];
        end
        PH_YR_DIV: begin
          if (alu_carry) ymod_q <= alu_res[YrW-1:0];
        end
        PH_WALK: begin
          if (!stat.walk_done) begin
            day_q <= alu_res;
            if (mon_q[3:0] == MonthLast) begin
              mon_q  <= '0;
              yr_q   <= yr_q + YrW'(1);
              ymod_q <= (ymod_q == YrW'(LeapCycle - AluW'(1))) ? '0 : ymod_q + YrW'(1);
            end else begin
              mon_q <= mon_q + MonthInW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      year_out_q   <= (yr_q > YearMax) ? YearMax[YearW-1:0] : yr_q[YearW-1:0];
      month_out_q  <= mon_q[MonthOutW-1:0] + MonthOutW'(1);
      day_out_q    <= day_q[DayOutW-1:0];
      hour_out_q   <= hr_q[HourOutW-1:0];
      minute_out_q <= min_q[MinOutW-1:0];
    end
  end

  assign in_i.ready       = (ctrl.phase == PH_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.year_out   = year_out_q;
  assign out_o.month_out  = month_out_q;
  assign out_o.day_out    = day_out_q;
  assign out_o.hour_out   = hour_out_q;
  assign out_o.minute_out = minute_out_q;

  `DTN_ASSERT_NEXT(a_accept_starts, in_i.valid && in_i.ready, (ctrl.phase == PH_MIN_DIV) && (ctrl.step == MinStepTop), "accepted item did not start minute division")
  `DTN_ASSERT_IMPL(a_out_ranges, out_o.valid, (out_o.month_out != '0) && (out_o.month_out <= MonthOutW'(12)) && (out_o.hour_out < HourOutW'(24)) && (out_o.minute_out < MinOutW'(60)), "result field out of range")
  `DTN_ASSERT_IMPL(a_walk_mod, ctrl.phase == PH_WALK, (ymod_q < YrW'(LeapCycle)) && (mon_q < MonthInW'(12)), "year phase or month index out of range in walk")
  `DTN_ASSERT_IMPL(a_rise_from_done, $rose(out_o.valid), $past(ctrl.phase == PH_DONE), "result valid rose outside final phase")

endmodule

### dv/date_time_normalizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Date/time normalizer testbench
// Drives raw timestamps with random gaps and stalls, predicts each normalized
// date and time, and checks every result in order against the prediction.
// ----------------------------------------------------------------------------
module date_time_normalizer_tb;
  import dtn_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned RandomItems   = 230;
  localparam int unsigned SettleCycles  = 100;
  localparam int unsigned FebIdx        = 1;
  localparam int unsigned YearCeil      = 16383;
  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [YearW-1:0]    year;
    logic [MonthInW-1:0] month;
    logic [DayInW-1:0]   day;
    logic [HourInW-1:0]  hour;
    logic [MinInW-1:0]   minute;
  } stamp_t;

  typedef struct packed {
    logic [YearW-1:0]     year;
    logic [MonthOutW-1:0] month;
    logic [DayOutW-1:0]   day;
    logic [HourOutW-1:0]  hour;
    logic [MinOutW-1:0]   minute;
  } norm_t;

  class calendar_board;
    norm_t pending_dates[$];
    int    mismatches;

    function int unsigned month_length(int unsigned yr, int unsigned idx);
      bit leap;
      leap = ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
      if (idx == FebIdx && leap) return 29;
      return MonthDays[idx];
    endfunction

    function norm_t normalize(stamp_t s);
      int unsigned yr, mo, dy, hr, mi, idx;
      norm_t r;
      mi  = s.minute;
      hr  = s.hour + mi / 60;
      mi  = mi % 60;
      dy  = s.day + hr / 24;
      hr  = hr % 24;
      mo  = (s.month == 0) ? 1 : s.month;
      yr  = s.year + (mo - 1) / 12;
      idx = (mo - 1) % 12;
      while (dy > month_length(yr, idx)) begin
        dy -= month_length(yr, idx);
        idx++;
        if (idx == 12) begin
          idx = 0;
          yr++;
        end
      end
      if (yr > YearCeil) yr = YearCeil;
      r.year   = YearW'(yr);
      r.month  = MonthOutW'(idx + 1);
      r.day    = DayOutW'(dy);
      r.hour   = HourOutW'(hr);
      r.minute = MinOutW'(mi);
      return r;
    endfunction

    function void note_stamp(stamp_t s);
      pending_dates.push_back(normalize(s));
    endfunction

    function void check_norm(norm_t got);
      norm_t want;
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d-%0d-%0d %0d:%0d",
                   got.year, got.month, got.day, got.hour, got.minute);
        return;
      end
      want = pending_dates.pop_front();
      if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
          got.hour !== want.hour || got.minute !== want.minute) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %0d-%0d-%0d %0d:%0d, got %0d-%0d-%0d %0d:%0d",
                   want.year, want.month, want.day, want.hour, want.minute,
                   got.year, got.month, got.day, got.hour, got.minute);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  dtn_in_if  in_if ();
  dtn_out_if out_if ();

  date_time_normalizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  calendar_board board;
  int unsigned   src_calm;
  int unsigned   snk_calm;
  int unsigned   idle_cycles;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 30);
    return $urandom_range(0, 7);
  endfunction

  task automatic send_stamp(input int unsigned y, input int unsigned mo, input int unsigned d,
                            input int unsigned h, input int unsigned mi);
    int unsigned gap;
    gap = draw_wait(src_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.year_in   <= YearW'(y);
    in_if.month_in  <= MonthInW'(mo);
    in_if.day_in    <= DayInW'(d);
    in_if.hour_in   <= HourInW'(h);
    in_if.minute_in <= MinInW'(mi);
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending_dates.size() != 0);
  endtask

  task automatic send_random_stamp();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      send_stamp($urandom_range(0, 9999), $urandom_range(1, 12), $urandom_range(0, 31),
                 $urandom_range(0, 1) ? $urandom_range(0, 23) : $urandom_range(0, 100),
                 $urandom_range(0, 1) ? $urandom_range(0, 59) : $urandom_range(0, 2000));
    else if (pick < 90)
      send_stamp($urandom_range(0, 16383), $urandom_range(0, 255), $urandom_range(0, 1000),
                 $urandom_range(0, 2000), $urandom_range(0, 20000));
    else
      send_stamp($urandom_range(0, 16383), $urandom_range(0, 255), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
  endtask

  // sample both channels and watch for a hang
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if (in_if.valid && in_if.ready)
        board.note_stamp('{in_if.year_in, in_if.month_in, in_if.day_in,
                           in_if.hour_in, in_if.minute_in});
      if (out_if.valid && out_if.ready)
        board.check_norm('{out_if.year_out, out_if.month_out, out_if.day_out,
                           out_if.hour_out, out_if.minute_out});
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(snk_calm);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  initial begin
    board           = new();
    src_calm        = 0;
    snk_calm        = 0;
    rst_ni          = 1'b0;
    in_if.valid     <= 1'b0;
    in_if.year_in   <= '0;
    in_if.month_in  <= '0;
    in_if.day_in    <= '0;
    in_if.hour_in   <= '0;
    in_if.minute_in <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_stamp(0, 0, 0, 0, 0);
    send_stamp(0, 1, 1, 0, 0);
    send_stamp(9999, 12, 31, 23, 59);
    send_stamp(2023, 6, 15, 10, 60);
    send_stamp(2023, 6, 15, 23, 60);
    send_stamp(2023, 12, 31, 24, 0);
    send_stamp(2023, 3, 0, 23, 59);
    send_stamp(2023, 3, 0, 24, 0);
    send_stamp(2000, 2, 29, 0, 0);
    send_stamp(2000, 2, 30, 0, 0);
    send_stamp(1900, 2, 29, 0, 0);
    send_stamp(2004, 2, 29, 0, 0);
    send_stamp(2100, 2, 29, 0, 0);
    send_stamp(2023, 13, 1, 0, 0);
    send_stamp(2023, 24, 31, 0, 0);
    send_stamp(2023, 25, 1, 0, 0);
    send_stamp(2000, 1, 366, 0, 0);
    send_stamp(16383, 12, 32, 0, 0);
    send_stamp(16380, 255, 1, 0, 0);
    send_stamp(16383, 1, 0, 0, 0);
    send_stamp(1234, 7, 32768, 0, 0);
    send_stamp(5000, 128, 10, 65535, 0);
    send_stamp(3000, 3, 5, 0, 65535);
    send_stamp(16383, 255, 65535, 65535, 65535);
    drain_results();

    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 2) drain_results();
      send_random_stamp();
    end

    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending_dates.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_dates.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
